// ===== src/boid_pkg.sv =====
// Shared types and constants for the BER object identifier decoder.
package boid_pkg;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_ARC   = 3'd0,
      ST_SHORT = 3'd1,
      ST_TAG   = 3'd2,
      ST_LEN   = 3'd3,
      ST_TRUNC = 3'd4,
      ST_LONG  = 3'd5
   } status_type;

   // Where the decoder stands within one encoding.
   typedef enum logic [1:0] {
      POS_TAG   = 2'd0,
      POS_LEN   = 2'd1,
      POS_FIRST = 2'd2,
      POS_SUBID = 2'd3
   } pos_type;

   localparam logic [7:0] OID_TAG    = 8'h06;
   localparam logic [7:0] FIRST_DIV  = 8'd40;
   localparam int         ARC_BITS   = 32;

   // Result queue geometry.
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic [ARC_BITS-1:0] arc;
      status_type          status;
      logic                last;
   } result_type;

   // Up to two results produced by one input word.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

// ===== src/ber_oid_decoder.sv =====
// Top level of the BER object identifier decoder.
//
// This block decodes a BER-encoded OBJECT IDENTIFIER presented one byte per
// word on the req_ stream, with req_tlast marking the last byte of the
// encoding. It checks the tag byte and the short-form length byte, splits the
// first content byte into two arcs by 40, and assembles each later
// subidentifier base-128 into an arc that wraps on overflow. Arcs leave on the
// rsp_ stream with status zero, and rsp_tlast marks the final result of an
// identifier. On an error a single result with a nonzero status and rsp_tlast
// set is sent, the rest of the encoding up to the byte marked last is
// swallowed, and the consumer should discard any arcs it already took for
// that identifier. The block takes one byte per clock cycle while req_tready
// is high; each result is registered in the result queue when its byte is
// accepted. The sustained rate is set by the four-entry result queue:
// req_tready is high while at least two entries are free, so it only falls
// when the consumer stalls. There is no clearing pass after reset.
module ber_oid_decoder #(
   parameter int MAX_CONTINUATIONS = 4,
   parameter int ARC_WIDTH         = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   input  logic        req_tlast,   // final_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] arc_value, [34:32] status, rest zero
   output logic        rsp_tlast    // last
);

   boid_pkg::push_type   push;
   boid_pkg::result_type head;
   logic                 accept;
   logic                 has_room;
   logic                 not_empty;

   // A byte is taken only when the queue can absorb the two results it may
   // cause.
   assign req_tready = has_room;
   assign accept     = req_tvalid && has_room;

   boid_step #(
      .MAX_CONTINUATIONS(MAX_CONTINUATIONS),
      .ARC_WIDTH        (ARC_WIDTH)
   ) u_step (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .byte_in   (req_tdata),
      .final_byte(req_tlast),
      .push      (push)
   );

   boid_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (rsp_tready),
      .has_room (has_room),
      .not_empty(not_empty),
      .head     (head)
   );

   assign rsp_tvalid = not_empty;
   assign rsp_tdata  = {5'b0, head.status, head.arc};
   assign rsp_tlast  = head.last;

`ifndef ASSERT_OFF
   // A result is offered only after some byte has been accepted since reset.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_tvalid) && !$past(reset)) |-> $past(accept))
      else $error("result appeared without an accepted byte");
`endif

endmodule

// ===== src/boid_step.sv =====
// Per-byte decode logic and the decoder state registers.
module boid_step #(
   parameter int MAX_CONTINUATIONS = 4,
   parameter int ARC_WIDTH         = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         byte_in,
   input  logic               final_byte,
   output boid_pkg::push_type push
);

   localparam int CW = $clog2(MAX_CONTINUATIONS + 1);
   localparam logic [CW:0] MAXC = (CW + 1)'(MAX_CONTINUATIONS);

   boid_pkg::pos_type    pos_ff, pos_in;
   boid_pkg::status_type hdr_ff, hdr_in;
   logic [ARC_WIDTH-1:0] acc_ff, acc_in, acc_shift;
   logic [CW-1:0]        cc_ff, cc_in;
   logic [CW:0]          cc_inc;
   logic                 drop_ff, drop_in;
   logic [4:0]           q_div8;
   logic [7:0]           quot, rem;
   logic [7:0]           prod;
   logic [ARC_WIDTH+31:0] acc_wide;

   // Divide by 40 as (b/8)/5, with /5 done by the reciprocal 13/64.
   always_comb begin
      q_div8 = byte_in[7:3];
      prod   = 8'(({5'b0, q_div8} * 10'd13) >> 6);
      quot   = prod;
      rem    = 8'(byte_in - 8'(quot * boid_pkg::FIRST_DIV));
   end

   assign acc_shift = {acc_ff[ARC_WIDTH-8:0], byte_in[6:0]};
   assign acc_wide  = {32'b0, acc_shift};
   assign cc_inc    = {1'b0, cc_ff} + (CW + 1)'(1);

   // Next state.
   always_comb begin
      pos_in  = pos_ff;
      hdr_in  = hdr_ff;
      acc_in  = acc_ff;
      cc_in   = cc_ff;
      drop_in = drop_ff;
      if (accept) begin
         if (drop_ff) begin
            if (final_byte) begin
               drop_in = 1'b0;
               pos_in  = boid_pkg::POS_TAG;
               hdr_in  = boid_pkg::ST_ARC;
               acc_in  = '0;
               cc_in   = '0;
            end
         end else begin
            case (pos_ff)
               boid_pkg::POS_TAG: begin
                  if (!final_byte) begin
                     hdr_in = (byte_in != boid_pkg::OID_TAG) ? boid_pkg::ST_TAG
                                                             : boid_pkg::ST_ARC;
                     pos_in = boid_pkg::POS_LEN;
                  end
               end
               boid_pkg::POS_LEN: begin
                  if (final_byte) begin
                     pos_in = boid_pkg::POS_TAG;
                     hdr_in = boid_pkg::ST_ARC;
                  end else begin
                     if (hdr_ff == boid_pkg::ST_ARC && byte_in[7]) begin
                        hdr_in = boid_pkg::ST_LEN;
                     end
                     pos_in = boid_pkg::POS_FIRST;
                  end
               end
               boid_pkg::POS_FIRST: begin
                  if (hdr_ff != boid_pkg::ST_ARC) begin
                     drop_in = ~final_byte;
                     pos_in  = boid_pkg::POS_TAG;
                     hdr_in  = boid_pkg::ST_ARC;
                  end else begin
                     pos_in = final_byte ? boid_pkg::POS_TAG : boid_pkg::POS_SUBID;
                     acc_in = '0;
                     cc_in  = '0;
                  end
               end
               boid_pkg::POS_SUBID: begin
                  if (byte_in[7]) begin
                     if (final_byte || cc_inc > MAXC) begin
                        // Truncated or overlong subidentifier: restart.
                        drop_in = ~final_byte;
                        pos_in  = boid_pkg::POS_TAG;
                        acc_in  = '0;
                        cc_in   = '0;
                     end else begin
                        acc_in = acc_shift;
                        cc_in  = cc_inc[CW-1:0];
                     end
                  end else begin
                     acc_in = '0;
                     cc_in  = '0;
                     if (final_byte) begin
                        pos_in = boid_pkg::POS_TAG;
                     end
                  end
               end
               default: begin
                  pos_in = boid_pkg::POS_TAG;
               end
            endcase
         end
      end
   end

   // Results caused by the accepted byte.
   always_comb begin
      push = '0;
      if (accept && !drop_ff) begin
         case (pos_ff)
            boid_pkg::POS_TAG: begin
               if (final_byte) begin
                  push.count        = 2'd1;
                  push.first.status = boid_pkg::ST_SHORT;
                  push.first.last   = 1'b1;
               end
            end
            boid_pkg::POS_LEN: begin
               if (final_byte) begin
                  push.count        = 2'd1;
                  push.first.status = boid_pkg::ST_SHORT;
                  push.first.last   = 1'b1;
               end
            end
            boid_pkg::POS_FIRST: begin
               if (hdr_ff != boid_pkg::ST_ARC) begin
                  push.count        = 2'd1;
                  push.first.status = hdr_ff;
                  push.first.last   = 1'b1;
               end else begin
                  push.count         = 2'd2;
                  push.first.arc     = 32'(quot);
                  push.first.status  = boid_pkg::ST_ARC;
                  push.second.arc    = 32'(rem);
                  push.second.status = boid_pkg::ST_ARC;
                  push.second.last   = final_byte;
               end
            end
            boid_pkg::POS_SUBID: begin
               if (byte_in[7]) begin
                  if (final_byte || cc_inc > MAXC) begin
                     push.count        = 2'd1;
                     push.first.status = final_byte ? boid_pkg::ST_TRUNC
                                                    : boid_pkg::ST_LONG;
                     push.first.last   = 1'b1;
                  end
               end else begin
                  push.count        = 2'd1;
                  push.first.arc    = acc_wide[31:0];
                  push.first.status = boid_pkg::ST_ARC;
                  push.first.last   = final_byte;
               end
            end
            default: begin
               push = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= boid_pkg::POS_TAG;
         hdr_ff  <= boid_pkg::ST_ARC;
         acc_ff  <= '0;
         cc_ff   <= '0;
         drop_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         hdr_ff  <= hdr_in;
         acc_ff  <= acc_in;
         cc_ff   <= cc_in;
         drop_ff <= drop_in;
      end
   end

`ifndef ASSERT_OFF
   // While dropping, the decoder always waits at the start of a new encoding.
   a_drop_restarts: assert property (@(posedge clock) disable iff (reset)
      drop_ff |-> (pos_ff == boid_pkg::POS_TAG && cc_ff == '0))
      else $error("dropping with decode state not cleared");

   // Every error result closes the identifier.
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0 && push.first.status != boid_pkg::ST_ARC)
         |-> (push.first.last && push.count == 2'd1))
      else $error("error result without last");
`endif

endmodule

// ===== src/boid_queue.sv =====
// Small result queue that accepts up to two results per cycle.
module boid_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  boid_pkg::push_type   push,
   input  logic                 pop,
   output logic                 has_room,
   output logic                 not_empty,
   output boid_pkg::result_type head
);

   boid_pkg::result_type                entry_ff [boid_pkg::QDEPTH];
   logic [boid_pkg::QPTR_W-1:0]         wr_ff, wr_in, rd_ff, rd_in, wr_next;
   logic [boid_pkg::QCNT_W-1:0]         cnt_ff, cnt_in;
   logic                                do_pop;

   assign not_empty = (cnt_ff != '0);
   assign has_room  = (cnt_ff <= boid_pkg::QCNT_W'(boid_pkg::QDEPTH - 2));
   assign head      = entry_ff[rd_ff];
   assign do_pop    = pop && not_empty;
   assign wr_next   = wr_ff + boid_pkg::QPTR_W'(1);

   always_comb begin
      wr_in  = wr_ff + boid_pkg::QPTR_W'(push.count);
      rd_in  = rd_ff + boid_pkg::QPTR_W'(do_pop);
      cnt_in = cnt_ff + boid_pkg::QCNT_W'(push.count) - boid_pkg::QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

`ifndef ASSERT_OFF
   // A push never overruns the entries that are still free.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> (32'(push.count) + 32'(cnt_ff) <= boid_pkg::QDEPTH))
      else $error("result queue overrun");

   // The pointers stay consistent with the fill count.
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (wr_ff - rd_ff) == cnt_ff[boid_pkg::QPTR_W-1:0])
      else $error("queue pointers disagree with count");
`endif

endmodule
